// File: design/ceq_pkg.sv
// Package: types and constants of the coalescing event queue.
`default_nettype none
package ceq_pkg;
    localparam int QueueDepth = 16;
    localparam int SlotCount  = 4;
    localparam int PosW   = $clog2(QueueDepth);
    localparam int FillW  = $clog2(QueueDepth + 1);
    localparam int SlotW  = $clog2(SlotCount);
    localparam int AddrW  = SlotW + PosW;
    localparam int EntryDepth = SlotCount * QueueDepth;
    localparam int EntryW = 128;
    localparam logic [31:0] RateWindowMs = 32'd1000;
    localparam logic [15:0] MergeMax = 16'hFFFF;

    typedef enum logic [2:0] {
        K_POST    = 3'd0,
        K_CONSOLE = 3'd1,
        K_TAKE    = 3'd2,
        K_RESET   = 3'd3,
        K_FLUSH   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        O_APPENDED  = 3'd0,
        O_MERGED    = 3'd1,
        O_LOST      = 3'd2,
        O_INVALID   = 3'd3,
        O_DELIVERED = 3'd4,
        O_EMPTY     = 3'd5,
        O_DONE      = 3'd6
    } t_outcome;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [7:0]  source;
        logic [7:0]  event_id;
        logic [31:0] payload;
        logic [31:0] now_ms;
        logic [31:0] cycle_stamp;
        logic [15:0] limit;
    } t_req;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  out_source;
        logic [7:0]  out_id;
        logic [15:0] out_merges;
        logic [31:0] out_payload;
        logic [31:0] out_tick;
        logic [31:0] out_cycles;
        logic [31:0] delivered_total;
        logic [31:0] lost_total;
        logic [31:0] merged_total;
        logic [31:0] peak_rate;
    } t_rsp;
endpackage
`default_nettype wire

// File: design/ceq_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ceq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/coalescing_event_queue_top.sv
// Top level: per-slot coalescing event queues with a one-second rate window.
// One request at a time. A post scans the queued entries from the head, one entry
// read and compared per cycle through the entry RAM's single read port. That port
// sets the pace. A post with no match reads every queued entry; a match at the
// k-th entry ends the scan early. Take, console post, reset, flush, unknown kinds
// and an invalid slot do not scan. The result waits for ready, and no new request
// is taken meanwhile. Entries that were never written hold no defined value.
`default_nettype none
module coalescing_event_queue_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ceq_pkg::t_req   i_req,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ceq_pkg::t_rsp        o_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [7:0]      i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_END   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    localparam int PW = ceq_pkg::PosW;
    localparam int FW = ceq_pkg::FillW;
    localparam int AW = ceq_pkg::AddrW;
    localparam int SC = ceq_pkg::SlotCount;

    t_state r_state, n_state;
    ceq_pkg::t_req r_req;
    ceq_pkg::t_rsp r_rsp, n_rsp;
    logic [7:0] r_console;

    logic [PW-1:0] r_head [SC];
    logic [PW-1:0] r_tail [SC];
    logic [FW-1:0] r_fill [SC];
    logic [FW-1:0] r_limit [SC];
    logic [31:0] r_deliv [SC];
    logic [31:0] r_lost [SC];
    logic [31:0] r_merged [SC];
    logic [31:0] r_wbegin [SC];
    logic [31:0] r_wposts [SC];
    logic [31:0] r_peak [SC];

    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_cnt;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [127:0]  wdata, rdata;

    logic [ceq_pkg::SlotW-1:0] sl;
    logic slot_ok;
    assign sl = r_req.slot[ceq_pkg::SlotW-1:0];
    assign slot_ok = {1'b0, r_req.slot} < 4'(SC);

    logic [PW-1:0] pos_nx;
    assign pos_nx = (r_pos == PW'(ceq_pkg::QueueDepth - 1)) ? '0 : r_pos + 1'b1;
    logic [PW-1:0] tail_nx;
    assign tail_nx = (r_tail[sl] == PW'(ceq_pkg::QueueDepth - 1)) ? '0 :
                     r_tail[sl] + 1'b1;
    logic [PW-1:0] head_nx;
    assign head_nx = (r_head[sl] == PW'(ceq_pkg::QueueDepth - 1)) ? '0 :
                     r_head[sl] + 1'b1;

    logic hit;
    assign hit = rdata[127:120] == r_req.source && rdata[119:112] == r_req.event_id;
    logic [15:0] merges_nx;
    assign merges_nx = (rdata[111:96] < ceq_pkg::MergeMax) ? rdata[111:96] + 16'd1 :
                       rdata[111:96];

    logic [FW-1:0] lim_req;
    assign lim_req = (r_req.limit == 16'd0 || r_req.limit > 16'(ceq_pkg::QueueDepth)) ?
                     FW'(ceq_pkg::QueueDepth) : r_req.limit[FW-1:0];

    ceq_ram #(.Width(ceq_pkg::EntryW), .Depth(ceq_pkg::EntryDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_rsp = r_rsp;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        we = 1'b0;
        waddr = {sl, r_tail[sl]};
        wdata = {r_req.source, r_req.event_id, 16'd1, r_req.payload,
                 r_req.now_ms, r_req.cycle_stamp};
        raddr = {sl, r_pos};
        n_state = r_state;
        n_rsp = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = slot_ok ? S_READ : S_OUT;
                n_rsp = '0;
                if (!slot_ok) begin
                    n_rsp.outcome = ceq_pkg::O_INVALID;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (r_req.kind == ceq_pkg::K_POST && r_cnt != '0) begin
                    if (hit) begin
                        we = 1'b1;
                        waddr = {sl, r_pos};
                        wdata = {rdata[127:112], merges_nx, r_req.payload,
                                 rdata[63:0]};
                        n_state = S_END;
                    end else begin
                        raddr = {sl, pos_nx};
                        n_state = S_CHECK;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_END: n_state = S_SUM;
            S_SUM: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_END && !r_rsp[0] && r_req.kind == ceq_pkg::K_POST) begin
            we = r_fill[sl] < r_limit[sl];
        end
        if (r_state == S_END && r_req.kind == ceq_pkg::K_CONSOLE) begin
            we = r_fill[sl] < r_limit[sl];
            wdata = {r_console, 8'd0, 16'd1, 32'd0, r_req.now_ms, r_req.cycle_stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_console <= 8'd3;
            for (int i = 0; i < SC; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
                r_limit[i] <= FW'(ceq_pkg::QueueDepth);
                r_deliv[i] <= '0;
                r_lost[i] <= '0;
                r_merged[i] <= '0;
                r_wbegin[i] <= '0;
                r_wposts[i] <= '0;
                r_peak[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_console <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                    end
                end
                S_START: begin
                    r_rsp <= n_rsp;
                    r_pos <= r_head[sl];
                    r_cnt <= r_fill[sl];
                    if (slot_ok && r_req.kind == ceq_pkg::K_POST) begin
                        if (r_req.now_ms - r_wbegin[sl] >= ceq_pkg::RateWindowMs) begin
                            if (r_wposts[sl] > r_peak[sl]) begin
                                r_peak[sl] <= r_wposts[sl];
                            end
                            r_wbegin[sl] <= r_req.now_ms;
                            r_wposts[sl] <= 32'd1;
                        end else begin
                            r_wposts[sl] <= r_wposts[sl] + 32'd1;
                        end
                    end
                end
                S_READ: begin
                    r_pos <= r_pos;
                end
                S_CHECK: begin
                    if (r_req.kind == ceq_pkg::K_POST && r_cnt != '0) begin
                        if (hit) begin
                            r_rsp[0] <= 1'b1;
                            r_merged[sl] <= r_merged[sl] + 32'd1;
                        end else begin
                            r_pos <= pos_nx;
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                end
                S_END: begin
                    priority case (r_req.kind)
                        ceq_pkg::K_POST, ceq_pkg::K_CONSOLE: begin
                            if (r_req.kind == ceq_pkg::K_POST && r_rsp[0]) begin
                                r_rsp.outcome <= ceq_pkg::O_MERGED;
                            end else if (r_fill[sl] < r_limit[sl]) begin
                                r_rsp.outcome <= ceq_pkg::O_APPENDED;
                                r_tail[sl] <= tail_nx;
                                r_fill[sl] <= r_fill[sl] + 1'b1;
                            end else begin
                                r_rsp.outcome <= ceq_pkg::O_LOST;
                                if (r_req.kind == ceq_pkg::K_POST) begin
                                    r_lost[sl] <= r_lost[sl] + 32'd1;
                                end
                            end
                        end
                        ceq_pkg::K_TAKE: begin
                            if (r_fill[sl] != '0) begin
                                r_rsp.outcome <= ceq_pkg::O_DELIVERED;
                                r_rsp.out_source <= rdata[127:120];
                                r_rsp.out_id <= rdata[119:112];
                                r_rsp.out_merges <= rdata[111:96];
                                r_rsp.out_payload <= rdata[95:64];
                                r_rsp.out_tick <= rdata[63:32];
                                r_rsp.out_cycles <= rdata[31:0];
                                r_head[sl] <= head_nx;
                                r_fill[sl] <= r_fill[sl] - 1'b1;
                                r_deliv[sl] <= r_deliv[sl] + 32'd1;
                            end else begin
                                r_rsp.outcome <= ceq_pkg::O_EMPTY;
                            end
                        end
                        ceq_pkg::K_RESET: begin
                            r_rsp.outcome <= ceq_pkg::O_DONE;
                            r_head[sl] <= '0;
                            r_tail[sl] <= '0;
                            r_fill[sl] <= '0;
                            r_deliv[sl] <= '0;
                            r_lost[sl] <= '0;
                            r_merged[sl] <= '0;
                            r_wbegin[sl] <= r_req.now_ms;
                            r_wposts[sl] <= '0;
                            r_peak[sl] <= '0;
                            r_limit[sl] <= lim_req;
                        end
                        ceq_pkg::K_FLUSH: begin
                            r_rsp.outcome <= ceq_pkg::O_DONE;
                            r_head[sl] <= '0;
                            r_tail[sl] <= '0;
                            r_fill[sl] <= '0;
                        end
                        default: begin
                            r_rsp.outcome <= ceq_pkg::O_DONE;
                        end
                    endcase
                end
                S_SUM: begin
                    r_rsp.delivered_total <= r_deliv[sl];
                    r_rsp.lost_total <= r_lost[sl];
                    r_rsp.merged_total <= r_merged[sl];
                    r_rsp.peak_rate <= r_peak[sl];
                end
                default: begin
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("accept during result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
endmodule
`default_nettype wire

// File: verif/ceq_checker.sv
// Checker: watches the request, response and register channels, predicts and compares.
module ceq_checker
    import ceq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready_dut,
    input  t_req       i_req,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_rsp       i_rsp,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] ent_key   [SlotCount][QueueDepth];
    logic [31:0] ent_value [SlotCount][QueueDepth];
    logic [31:0] ent_tick  [SlotCount][QueueDepth];
    logic [31:0] ent_cyc   [SlotCount][QueueDepth];
    int unsigned head_q [SlotCount];
    int unsigned tail_q [SlotCount];
    int unsigned fill_q [SlotCount];
    int unsigned depth_q [SlotCount];
    logic [31:0] delivered_q [SlotCount];
    logic [31:0] lost_q [SlotCount];
    logic [31:0] merged_q [SlotCount];
    logic [31:0] win_start [SlotCount];
    logic [31:0] win_posts [SlotCount];
    logic [31:0] peak_q [SlotCount];
    logic [7:0]  console_src;
    t_rsp        expected_rsps [$];
    int          fails;
    int          queued;

    assign o_fail_count = fails;
    assign o_pending = queued;

    function automatic void store_entry(int unsigned s, logic [7:0] src, logic [7:0] id,
                                        logic [31:0] val, logic [31:0] tick,
                                        logic [31:0] cyc);
        ent_key[s][tail_q[s]]   = {src, id, 16'd1};
        ent_value[s][tail_q[s]] = val;
        ent_tick[s][tail_q[s]]  = tick;
        ent_cyc[s][tail_q[s]]   = cyc;
        tail_q[s] = (tail_q[s] + 1) % QueueDepth;
        fill_q[s]++;
    endfunction

    function automatic t_rsp predict_outcome(t_req r);
        t_rsp o;
        int unsigned s, pos, n;
        logic [15:0] m;
        logic found;
        o = '0;
        s = r.slot;
        if (s >= SlotCount) begin
            o.outcome = O_INVALID;
            return o;
        end
        o.outcome = O_DONE;
        case (r.kind)
            K_POST: begin
                if (r.now_ms - win_start[s] >= RateWindowMs) begin
                    if (win_posts[s] > peak_q[s]) peak_q[s] = win_posts[s];
                    win_start[s] = r.now_ms;
                    win_posts[s] = 0;
                end
                win_posts[s]++;
                found = 1'b0;
                pos = head_q[s];
                for (n = 0; n < fill_q[s] && !found; n++) begin
                    if (ent_key[s][pos][31:16] == {r.source, r.event_id}) begin
                        found = 1'b1;
                        ent_value[s][pos] = r.payload;
                        m = ent_key[s][pos][15:0];
                        if (m != MergeMax) m++;
                        ent_key[s][pos][15:0] = m;
                        merged_q[s]++;
                        o.outcome = O_MERGED;
                    end
                    pos = (pos + 1) % QueueDepth;
                end
                if (!found) begin
                    if (fill_q[s] >= depth_q[s]) begin
                        lost_q[s]++;
                        o.outcome = O_LOST;
                    end else begin
                        store_entry(s, r.source, r.event_id, r.payload, r.now_ms,
                                    r.cycle_stamp);
                        o.outcome = O_APPENDED;
                    end
                end
            end
            K_CONSOLE: begin
                if (fill_q[s] < depth_q[s]) begin
                    store_entry(s, console_src, 8'd0, 32'd0, r.now_ms, r.cycle_stamp);
                    o.outcome = O_APPENDED;
                end else begin
                    o.outcome = O_LOST;
                end
            end
            K_TAKE: begin
                if (fill_q[s] > 0) begin
                    pos = head_q[s];
                    o.out_source  = ent_key[s][pos][31:24];
                    o.out_id      = ent_key[s][pos][23:16];
                    o.out_merges  = ent_key[s][pos][15:0];
                    o.out_payload = ent_value[s][pos];
                    o.out_tick    = ent_tick[s][pos];
                    o.out_cycles  = ent_cyc[s][pos];
                    head_q[s] = (pos + 1) % QueueDepth;
                    fill_q[s]--;
                    delivered_q[s]++;
                    o.outcome = O_DELIVERED;
                end else begin
                    o.outcome = O_EMPTY;
                end
            end
            K_RESET: begin
                head_q[s] = 0;
                tail_q[s] = 0;
                fill_q[s] = 0;
                delivered_q[s] = 0;
                lost_q[s] = 0;
                merged_q[s] = 0;
                win_start[s] = r.now_ms;
                win_posts[s] = 0;
                peak_q[s] = 0;
                depth_q[s] = (r.limit == 0 || r.limit > QueueDepth) ? QueueDepth : r.limit;
            end
            K_FLUSH: begin
                head_q[s] = 0;
                tail_q[s] = 0;
                fill_q[s] = 0;
            end
            default: ;
        endcase
        o.delivered_total = delivered_q[s];
        o.lost_total = lost_q[s];
        o.merged_total = merged_q[s];
        o.peak_rate = peak_q[s];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int s = 0; s < SlotCount; s++) begin
                head_q[s] = 0;
                tail_q[s] = 0;
                fill_q[s] = 0;
                depth_q[s] = QueueDepth;
                delivered_q[s] = 0;
                lost_q[s] = 0;
                merged_q[s] = 0;
                win_start[s] = 0;
                win_posts[s] = 0;
                peak_q[s] = 0;
            end
            console_src = 8'd3;
            expected_rsps.delete();
            fails = 0;
            queued = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) console_src = i_cfg_data;
            if (i_valid && i_ready_dut) expected_rsps.push_back(predict_outcome(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected response %h", $time, i_rsp);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (i_rsp !== exp_rsp) begin
                        fails++;
                        $display("%0t: mismatch expected %p", $time, exp_rsp);
                        $display("%0t:          actual   %p", $time, i_rsp);
                    end
                end
            end
            queued = expected_rsps.size();
        end
    end
endmodule

// File: verif/tb.sv
// Testbench top: drives requests and register writes, gives the verdict.
module tb;
    import ceq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_ready;
    t_req       i_req = '0;
    logic       o_valid;
    logic       i_ready = 0;
    t_rsp       o_rsp;
    logic       i_cfg_valid = 0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;
    int         cycles = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    logic [7:0] cur_console = 8'd3;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    coalescing_event_queue_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    ceq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_dut(o_ready), .i_req(i_req),
        .i_rsp_valid(o_valid), .i_rsp_ready(i_ready), .i_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("coalescing_event_queue_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send(t_req r);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_valid <= 1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_console(logic [7:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        cur_console = v;
    endtask

    function automatic t_req rand_req(int phase_mix);
        t_req r;
        int pick;
        r.kind = t_kind'(K_POST);
        r.slot = 3'($urandom_range(SlotCount - 1));
        r.source = 8'($urandom_range(3));
        r.event_id = 8'($urandom_range(3));
        r.payload = $urandom;
        r.now_ms = 0;
        r.cycle_stamp = $urandom;
        r.limit = 16'($urandom_range(QueueDepth + 2));
        pick = $urandom_range(99);
        if (pick < 45) r.kind = K_POST;
        else if (pick < 52) r.kind = K_CONSOLE;
        else if (pick < 82) r.kind = K_TAKE;
        else if (pick < 86) r.kind = K_RESET;
        else if (pick < 89) r.kind = K_FLUSH;
        else if (pick < 91) r.kind = 3'($urandom_range(7, 5));
        else if (pick < 93) r.slot = 3'($urandom_range(7, SlotCount));
        else begin
            r.source = 8'($urandom);
            r.event_id = 8'($urandom);
            r.limit = 16'($urandom);
        end
        if (phase_mix == 1 && r.kind == K_POST && $urandom_range(3) == 0) begin
            r.source = cur_console;
            r.event_id = 0;
        end
        return r;
    endfunction

    initial begin
        t_req r;
        logic [31:0] now;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        now = 0;

        r = '0;
        r.kind = K_CONSOLE;
        send(r);
        r.kind = K_POST; r.source = 8'd3; r.event_id = 0; r.payload = 32'hFFFF_FFFF;
        r.now_ms = 32'd5; r.cycle_stamp = 32'hFFFF_FFFF;
        send(r);
        r.kind = K_TAKE;
        send(r);
        send(r);
        r.kind = K_RESET; r.slot = 1; r.limit = 16'd2; r.now_ms = 32'hFFFF_FF00;
        send(r);
        for (int i = 0; i < 4; i++) begin
            r.kind = K_POST; r.source = 8'hFF; r.event_id = 8'(i); r.payload = 32'(i);
            r.now_ms = 32'hFFFF_FF00 + 32'(i * 700);
            send(r);
        end
        r.kind = K_CONSOLE;
        send(r);
        r.kind = K_FLUSH;
        send(r);
        r.kind = K_RESET; r.limit = 16'hFFFF; r.now_ms = 0;
        send(r);
        r.kind = K_RESET; r.limit = 0; r.slot = 2;
        send(r);
        r.kind = 3'd7;
        send(r);
        r.kind = K_TAKE; r.slot = 3'd7;
        send(r);
        r.slot = 3'd4; r.kind = K_POST;
        send(r);
        r.slot = 0; r.kind = K_RESET; r.limit = 16'd16;
        send(r);

        write_console(8'hFF);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 12 : (phase == 1) ? 51 : 0;
            recv_idle = (phase == 0) ? 51 : (phase == 1) ? 12 : 0;
            for (int i = 0; i < 500; i++) begin
                r = rand_req(phase);
                now = now + $urandom_range(($urandom_range(9) == 0) ? 1500 : 120);
                r.now_ms = ($urandom_range(49) == 0) ? $urandom : now;
                send(r);
                if (i == 250) drain();
            end
            write_console(phase == 0 ? 8'h00 : 8'($urandom));
        end
        drain();
        if (fail_count == 0) $display("coalescing_event_queue_top regression: pass");
        else $display("coalescing_event_queue_top regression: fail");
        $finish;
    end
endmodule
